>>> hdl/sfcs_pkg.sv
// shared constants, codes and the crc-16 word step for the spi frame crc session engine
// no dependencies; compile first
`timescale 1ns / 1ps

package sfcs_pkg;

	// request frame layout: op, addr hi, addr lo, data msb..lsb
	localparam int FRAME_BYTES = 7;
	localparam int BIDX_W      = $clog2(FRAME_BYTES);
	localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(FRAME_BYTES - 1);

	// input function codes
	localparam logic [1:0] FUNC_BYTE   = 2'd0;
	localparam logic [1:0] FUNC_IDLE   = 2'd1;
	localparam logic [1:0] FUNC_RESYNC = 2'd2;

	// request op codes
	localparam logic [7:0] OP_READ  = 8'd0;
	localparam logic [7:0] OP_WRITE = 8'd1;
	localparam logic [7:0] OP_PUSH  = 8'd3;

	// response status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_BAD_OP   = 3'd1;
	localparam logic [2:0] STAT_BAD_ADDR = 3'd2;
	localparam logic [2:0] STAT_BUSY     = 3'd3;
	localparam logic [2:0] STAT_CRC_ERR  = 3'd4;

	// crc session states
	localparam logic [1:0] SESS_NONE    = 2'd0;
	localparam logic [1:0] SESS_COLLECT = 2'd1;
	localparam logic [1:0] SESS_OK      = 2'd2;
	localparam logic [1:0] SESS_ERR     = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_CRC_WORD   = 3'd0;
	localparam logic [2:0] CFG_CMD_WORD   = 3'd1;
	localparam logic [2:0] CFG_PUSH_WORD  = 3'd2;
	localparam logic [2:0] CFG_IMG_WORDS  = 3'd3;
	localparam logic [2:0] CFG_IMG_COLS   = 3'd4;
	localparam logic [2:0] CFG_PACKED_RUN = 3'd5;
	localparam logic [2:0] CFG_IDLE_LIMIT = 3'd6;

	// crc-16/ccitt-false
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// one 32-bit word, msb first, through the crc register
	function automatic logic [15:0] crc16_word(input logic [15:0] crc_in, input logic [31:0] w);
		logic [15:0] c;
		logic        fb;
		c = crc_in;
		for (int i = 31; i >= 0; i--) begin
			fb = c[15] ^ w[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/sfcs_if.sv
// valid/ready channel interfaces for request beats and response beats
// depends on nothing; compile after sfcs_pkg
`timescale 1ns / 1ps

// request channel: one spi event per beat
interface sfcs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// response channel: one response per completed frame
interface sfcs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] addr_echo;
	logic [31:0] read_data;
	logic        write_valid;
	logic [6:0]  write_addr;
	logic [31:0] out_data;
	logic        push_valid;
	logic [1:0]  crc_status;

	modport source (output valid, output status, output addr_echo, output read_data,
		output write_valid, output write_addr, output out_data, output push_valid,
		output crc_status, input ready);
	modport sink (input valid, input status, input addr_echo, input read_data,
		input write_valid, input write_addr, input out_data, input push_valid,
		input crc_status, output ready);
endinterface

>>> hdl/sfcs_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependency
`timescale 1ns / 1ps

module sfcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/spi_frame_crc_session_engine.sv
// top level: spi request frame assembler, register window and crc-16 push session
// depends on sfcs_pkg, sfcs_if (sfcs_in_if, sfcs_out_if) and sfcs_ram
`timescale 1ns / 1ps

// channel  dir  beat content                                   handshake
// req      in   func, rx_byte (one spi event)                  valid/ready
// rsp      out  status, addr_echo, read_data, write/push info  valid/ready
// cfg      in   cfg_idx, cfg_wdata                             cfg_we, no wait
//
// one request beat can be taken every cycle, unless a frame's last byte waits for the read stage;
// a response passes from the input register through the window read to the output register.
// the window read and the session word count / column reads share the ram read port.
// reset: window entries read as zero through per-word valid bits, no clearing pass.
// a full output register stalls the frame stage only on a frame's last byte.

module spi_frame_crc_session_engine #(
	parameter int WINDOW_WORDS = 96
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	sfcs_in_if.sink    req,
	sfcs_out_if.source rsp
);

	localparam int AW = $clog2(WINDOW_WORDS);
	localparam logic [16:0] WIN_LIMIT = 17'(WINDOW_WORDS);

	// configuration registers
	logic [6:0] crc_word_addr_q, cmd_word_addr_q, push_word_addr_q;
	logic [6:0] img_words_addr_q, img_cols_addr_q;
	logic [7:0] packed_run_code_q, idle_limit_q;

	// input stage and assembler state
	logic                      s1_valid_s1;
	logic [1:0]                s1_func_s1;
	logic [7:0]                s1_byte_s1;
	logic [sfcs_pkg::BIDX_W-1:0] byte_index_q;
	logic [7:0]                idle_count_q;
	logic [7:0]                frame_q [sfcs_pkg::FRAME_BYTES-1];

	// window
	logic [WINDOW_WORDS-1:0] valid_q;
	logic                    rd_ok_q;
	logic                    ram_we, ram_re, rd_slot, rd_ok_d;
	logic [AW-1:0]           ram_raddr;
	logic [31:0]             ram_rdata, ram_word;

	// crc session
	logic [15:0] crc_accum_q, crc_expect_q;
	logic        crc_primed_q;
	logic [23:0] pushes_seen_q, session_total_q;
	logic [1:0]  session_state_q;

	// session start reads
	logic [2:0]    ss_step_q;
	logic [AW-1:0] ss_words_idx_q, ss_cols_idx_q;
	logic          ss_words_ok_q, ss_cols_ok_q, ss_packed_q;
	logic [15:0]   ss_words_q;
	logic [7:0]    ss_cols, ss_mul;

	// read stage
	logic        s2_valid_s2, s2_fresh_s2, s2_wv_s2, s2_pv_s2;
	logic [2:0]  s2_status_s2;
	logic [15:0] s2_addr_s2;
	logic [31:0] s2_rdata_s2, s2_od_s2, s2_read;
	logic [6:0]  s2_wa_s2;
	logic [1:0]  s2_crc_st_s2;

	// output register
	logic        out_valid_q, out_wv_q, out_pv_q;
	logic [2:0]  out_status_q;
	logic [15:0] out_addr_q;
	logic [31:0] out_rdata_q, out_od_q;
	logic [6:0]  out_wa_q;
	logic [1:0]  out_crc_st_q;

	// handshake and frame decode
	logic        s1_frame_done, s1_adv, s1_go, frame_go, s2_adv, s2_free;
	logic [7:0]  f_op, idle_inc;
	logic [15:0] f_addr, accum_step;
	logic [31:0] f_data, f_rdata, f_od;
	logic [23:0] seen_inc;
	logic [2:0]  f_status;
	logic [1:0]  sess_d;
	logic        is_crc, is_cmd, is_push, in_win, blocked, overrun;
	logic        f_use_ram, f_wv, f_pv, f_ram_we, f_rd, f_prime, f_start, f_collect;

	// stage flow control
	assign s2_adv        = s2_valid_s2 && (!out_valid_q || rsp.ready);
	assign s2_free       = !s2_valid_s2 || s2_adv;
	assign s1_frame_done = s1_valid_s1 && (s1_func_s1 == sfcs_pkg::FUNC_BYTE)
		&& (byte_index_q == sfcs_pkg::LAST_IDX);
	assign s1_adv        = !s1_frame_done || s2_free;
	assign s1_go         = s1_valid_s1 && s1_adv;
	assign frame_go      = s1_go && s1_frame_done;
	assign req.ready     = !s1_valid_s1 || s1_adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_word_addr_q   <= 7'd63;
			cmd_word_addr_q   <= 7'd0;
			push_word_addr_q  <= 7'd1;
			img_words_addr_q  <= 7'd2;
			img_cols_addr_q   <= 7'd3;
			packed_run_code_q <= 8'd0;
			idle_limit_q      <= 8'd25;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sfcs_pkg::CFG_CRC_WORD:   crc_word_addr_q   <= cfg_wdata[6:0];
				sfcs_pkg::CFG_CMD_WORD:   cmd_word_addr_q   <= cfg_wdata[6:0];
				sfcs_pkg::CFG_PUSH_WORD:  push_word_addr_q  <= cfg_wdata[6:0];
				sfcs_pkg::CFG_IMG_WORDS:  img_words_addr_q  <= cfg_wdata[6:0];
				sfcs_pkg::CFG_IMG_COLS:   img_cols_addr_q   <= cfg_wdata[6:0];
				sfcs_pkg::CFG_PACKED_RUN: packed_run_code_q <= cfg_wdata;
				sfcs_pkg::CFG_IDLE_LIMIT: idle_limit_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			s1_func_s1 <= req.func;
			s1_byte_s1 <= req.rx_byte;
		end
	end

	// frame assembler and idle gap counter
	assign idle_inc = (idle_count_q == 8'hFF) ? idle_count_q : idle_count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			idle_count_q <= '0;
		end else if (s1_go) begin
			case (s1_func_s1)
				sfcs_pkg::FUNC_BYTE: begin
					idle_count_q <= '0;
					if (byte_index_q < sfcs_pkg::LAST_IDX) begin
						byte_index_q <= byte_index_q + 1'b1;
					end else begin
						byte_index_q <= '0;
					end
				end
				sfcs_pkg::FUNC_IDLE: begin
					idle_count_q <= idle_inc;
					if (idle_inc > idle_limit_q) begin
						byte_index_q <= '0;
					end
				end
				sfcs_pkg::FUNC_RESYNC: begin
					idle_count_q <= '0;
					byte_index_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (s1_func_s1 == sfcs_pkg::FUNC_BYTE) && (byte_index_q < sfcs_pkg::LAST_IDX)) begin
			frame_q[byte_index_q] <= s1_byte_s1;
		end
	end

	// frame decode and execution
	always_comb begin
		f_op   = frame_q[0];
		f_addr = {frame_q[1], frame_q[2]};
		f_data = {frame_q[3], frame_q[4], frame_q[5], s1_byte_s1};

		is_crc  = f_addr == {9'd0, crc_word_addr_q};
		is_cmd  = f_addr == {9'd0, cmd_word_addr_q};
		is_push = f_addr == {9'd0, push_word_addr_q};
		in_win  = {1'b0, f_addr} < WIN_LIMIT;
		blocked = (session_state_q == sfcs_pkg::SESS_ERR) && (f_op != sfcs_pkg::OP_READ)
			&& !((f_op == sfcs_pkg::OP_WRITE) && is_cmd);
		overrun = (session_state_q != sfcs_pkg::SESS_NONE) && (session_total_q != 24'd0)
			&& (pushes_seen_q >= session_total_q);

		accum_step = sfcs_pkg::crc16_word(crc_accum_q, f_data);
		seen_inc   = pushes_seen_q + 24'd1;

		f_status  = (session_state_q == sfcs_pkg::SESS_ERR) ? sfcs_pkg::STAT_CRC_ERR
			: sfcs_pkg::STAT_OK;
		f_rdata   = '0;
		f_od      = '0;
		f_use_ram = 1'b0;
		f_wv      = 1'b0;
		f_pv      = 1'b0;
		f_ram_we  = 1'b0;
		f_rd      = 1'b0;
		f_prime   = 1'b0;
		f_start   = 1'b0;
		f_collect = 1'b0;

		case (f_op)
			sfcs_pkg::OP_READ: begin
				if (is_crc) begin
					f_rdata = {14'd0, session_state_q, crc_accum_q};
				end else if (in_win) begin
					f_use_ram = 1'b1;
					f_rd      = 1'b1;
				end else if (f_status == sfcs_pkg::STAT_OK) begin
					f_status = sfcs_pkg::STAT_BAD_ADDR;
				end
			end
			sfcs_pkg::OP_WRITE: begin
				if (!blocked) begin
					if (is_crc) begin
						f_prime = 1'b1;
					end else if (in_win) begin
						f_ram_we = 1'b1;
						f_wv     = 1'b1;
						f_od     = f_data;
						f_start  = is_cmd;
					end else if (f_status == sfcs_pkg::STAT_OK) begin
						f_status = sfcs_pkg::STAT_BAD_ADDR;
					end
				end
			end
			sfcs_pkg::OP_PUSH: begin
				if (!blocked) begin
					if (!is_push) begin
						if (f_status == sfcs_pkg::STAT_OK) begin
							f_status = sfcs_pkg::STAT_BAD_ADDR;
						end
					end else if (overrun) begin
						if (f_status == sfcs_pkg::STAT_OK) begin
							f_status = sfcs_pkg::STAT_BUSY;
						end
					end else begin
						f_collect = session_state_q == sfcs_pkg::SESS_COLLECT;
						f_pv      = 1'b1;
						f_od      = f_data;
					end
				end
			end
			default: begin
				if (f_status == sfcs_pkg::STAT_OK) begin
					f_status = sfcs_pkg::STAT_BAD_OP;
				end
			end
		endcase

		// session state after this frame
		sess_d = session_state_q;
		if (f_start) begin
			sess_d = crc_primed_q ? sfcs_pkg::SESS_COLLECT : sfcs_pkg::SESS_NONE;
		end else if (f_collect && (session_total_q != 24'd0) && (seen_inc == session_total_q)) begin
			sess_d = (accum_step == crc_expect_q) ? sfcs_pkg::SESS_OK : sfcs_pkg::SESS_ERR;
		end
	end

	// crc session registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_accum_q     <= sfcs_pkg::CRC_INIT;
			crc_expect_q    <= '0;
			crc_primed_q    <= 1'b0;
			pushes_seen_q   <= '0;
			session_state_q <= sfcs_pkg::SESS_NONE;
		end else if (frame_go) begin
			session_state_q <= sess_d;
			if (f_prime) begin
				crc_expect_q <= f_data[15:0];
				crc_primed_q <= 1'b1;
			end
			if (f_start) begin
				crc_accum_q   <= sfcs_pkg::CRC_INIT;
				pushes_seen_q <= '0;
				crc_primed_q  <= 1'b0;
			end
			if (f_collect) begin
				crc_accum_q   <= accum_step;
				pushes_seen_q <= seen_inc;
			end
		end
	end

	// session start: read word count, then columns, then form the total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ss_step_q       <= '0;
			session_total_q <= '0;
		end else begin
			ss_step_q <= {ss_step_q[1:0], frame_go && f_start};
			if (ss_step_q[2]) begin
				session_total_q <= 24'(ss_words_q) * 24'(ss_mul);
			end
		end
	end

	assign ss_cols = ram_word[7:0];
	assign ss_mul  = (ss_packed_q && (ss_cols != 8'd0)) ? ss_cols : 8'd1;

	always_ff @(posedge clk) begin
		if (frame_go && f_start) begin
			ss_words_idx_q <= AW'(img_words_addr_q);
			ss_words_ok_q  <= 17'(img_words_addr_q) < WIN_LIMIT;
			ss_cols_idx_q  <= AW'(img_cols_addr_q);
			ss_cols_ok_q   <= 17'(img_cols_addr_q) < WIN_LIMIT;
			ss_packed_q    <= f_data[7:0] == packed_run_code_q;
		end
		if (ss_step_q[1]) begin
			ss_words_q <= ram_word[15:0];
		end
	end

	// ram read port: frame read first, then session start reads
	always_comb begin
		rd_slot   = 1'b0;
		ram_re    = 1'b0;
		rd_ok_d   = 1'b0;
		ram_raddr = f_addr[AW-1:0];
		if (frame_go && f_rd) begin
			rd_slot = 1'b1;
			ram_re  = 1'b1;
			rd_ok_d = valid_q[f_addr[AW-1:0]];
		end else if (ss_step_q[0]) begin
			rd_slot   = 1'b1;
			ram_re    = ss_words_ok_q;
			ram_raddr = ss_words_idx_q;
			rd_ok_d   = ss_words_ok_q ? valid_q[ss_words_idx_q] : 1'b0;
		end else if (ss_step_q[1]) begin
			rd_slot   = 1'b1;
			ram_re    = ss_cols_ok_q;
			ram_raddr = ss_cols_idx_q;
			rd_ok_d   = ss_cols_ok_q ? valid_q[ss_cols_idx_q] : 1'b0;
		end
	end

	assign ram_we   = frame_go && f_ram_we;
	assign ram_word = rd_ok_q ? ram_rdata : 32'd0;

	// per-word valid bits stand in for the cleared window after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[f_addr[AW-1:0]] <= 1'b1;
			end
			if (rd_slot) begin
				rd_ok_q <= rd_ok_d;
			end
		end
	end

	sfcs_ram #(
		.WIDTH(32),
		.DEPTH(WINDOW_WORDS)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(f_addr[AW-1:0]),
		.wdata(f_data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read stage: window data arrives the cycle after the frame
	assign s2_read = s2_fresh_s2 ? ram_word : s2_rdata_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
			s2_fresh_s2 <= 1'b0;
		end else if (frame_go) begin
			s2_valid_s2 <= 1'b1;
			s2_fresh_s2 <= f_use_ram;
		end else begin
			s2_fresh_s2 <= 1'b0;
			if (s2_adv) begin
				s2_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_go) begin
			s2_status_s2 <= f_status;
			s2_addr_s2   <= f_addr;
			s2_rdata_s2  <= f_rdata;
			s2_wv_s2     <= f_wv;
			s2_wa_s2     <= f_wv ? f_addr[6:0] : 7'd0;
			s2_od_s2     <= f_od;
			s2_pv_s2     <= f_pv;
			s2_crc_st_s2 <= sess_d;
		end else if (s2_fresh_s2) begin
			s2_rdata_s2 <= ram_word;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_status_q <= s2_status_s2;
			out_addr_q   <= s2_addr_s2;
			out_rdata_q  <= s2_read;
			out_wv_q     <= s2_wv_s2;
			out_wa_q     <= s2_wa_s2;
			out_od_q     <= s2_od_s2;
			out_pv_q     <= s2_pv_s2;
			out_crc_st_q <= s2_crc_st_s2;
		end
	end

	// response beat
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.addr_echo   = out_addr_q;
	assign rsp.read_data   = out_rdata_q;
	assign rsp.write_valid = out_wv_q;
	assign rsp.write_addr  = out_wa_q;
	assign rsp.out_data    = out_od_q;
	assign rsp.push_valid  = out_pv_q;
	assign rsp.crc_status  = out_crc_st_q;

endmodule

>>> tb/sfcs_response_checker.sv
// response checker for the spi frame crc session engine: models frames, window and crc session
// depends on sfcs_pkg and the sfcs_in_if / sfcs_out_if channel interfaces
`timescale 1ns / 1ps

module sfcs_response_checker #(
	parameter int WINDOW_WORDS = 96
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [7:0] cfg_wdata,
	sfcs_in_if         req,
	sfcs_out_if        rsp,
	output int         errors,
	output int         pending,
	output int         checked
);
	import sfcs_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] addr_echo;
		logic [31:0] read_data;
		logic        write_valid;
		logic [6:0]  write_addr;
		logic [31:0] out_data;
		logic        push_valid;
		logic [1:0]  crc_status;
	} resp_t;

	resp_t expected_rsp[$];
	resp_t want;
	int    error_count;
	int    checked_count;

	// register copies
	logic [6:0] crc_addr, cmd_addr, push_addr, words_addr, cols_addr;
	logic [7:0] run_code, idle_lim;

	// modeled block state
	logic [7:0]  frame_buf [0:FRAME_BYTES-2];
	int unsigned fill;
	logic [7:0]  idle_ticks;
	logic [31:0] window [0:WINDOW_WORDS-1];
	logic [15:0] crc_acc, crc_target;
	logic        armed;
	logic [23:0] push_count, push_total;
	logic [1:0]  sess;

	// crc-16/ccitt-false over one word, a byte at a time, msb first
	function automatic logic [15:0] crc_after_word(input logic [15:0] acc, input logic [31:0] w);
		logic [15:0] r;
		r = acc;
		for (int j = 3; j >= 0; j--) begin
			r = r ^ {w[j*8 +: 8], 8'h00};
			for (int k = 0; k < 8; k++) begin
				r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got);
		if (got !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got);
			error_count++;
		end
	endtask

	// one request beat through the model; a frame's last byte queues a response
	task automatic absorb_beat(input logic [1:0] f, input logic [7:0] b);
		logic [7:0]  op;
		logic [15:0] addr;
		logic [31:0] data;
		logic        blocked;
		int unsigned words, cols, mul;
		resp_t       r;
		r = '0;
		blocked = 1'b0;
		case (f)
			FUNC_IDLE: begin
				if (idle_ticks != 8'hFF) begin
					idle_ticks = idle_ticks + 8'd1;
				end
				if (idle_ticks > idle_lim) begin
					fill = 0;
				end
			end
			FUNC_RESYNC: begin
				fill = 0;
				idle_ticks = '0;
			end
			FUNC_BYTE: begin
				idle_ticks = '0;
				if (fill < FRAME_BYTES - 1) begin
					frame_buf[fill] = b;
					fill++;
				end else begin
					fill = 0;
					op = frame_buf[0];
					addr = {frame_buf[1], frame_buf[2]};
					data = {frame_buf[3], frame_buf[4], frame_buf[5], b};

					// sticky error: only reads and command-word writes get through
					if (sess == SESS_ERR) begin
						r.status = STAT_CRC_ERR;
						blocked = (op != OP_READ) && !(op == OP_WRITE && addr == 16'(cmd_addr));
					end

					if (op == OP_READ) begin
						if (addr == 16'(crc_addr)) begin
							r.read_data = {14'd0, sess, crc_acc};
						end else if (addr < WINDOW_WORDS) begin
							r.read_data = window[addr];
						end else if (r.status == STAT_OK) begin
							r.status = STAT_BAD_ADDR;
						end
					end else if (op == OP_WRITE) begin
						if (!blocked) begin
							if (addr == 16'(crc_addr)) begin
								crc_target = data[15:0];
								armed = 1'b1;
							end else if (addr < WINDOW_WORDS) begin
								window[addr] = data;
								r.write_valid = 1'b1;
								r.write_addr = addr[6:0];
								r.out_data = data;
								// command write opens a session sized from the window
								if (addr == 16'(cmd_addr)) begin
									words = (words_addr < WINDOW_WORDS) ? window[words_addr][15:0] : 0;
									cols = (cols_addr < WINDOW_WORDS) ? window[cols_addr][7:0] : 0;
									mul = (data[7:0] == run_code && cols != 0) ? cols : 1;
									crc_acc = CRC_INIT;
									push_count = '0;
									push_total = 24'(words * mul);
									sess = armed ? SESS_COLLECT : SESS_NONE;
									armed = 1'b0;
								end
							end else if (r.status == STAT_OK) begin
								r.status = STAT_BAD_ADDR;
							end
						end
					end else if (op == OP_PUSH) begin
						if (!blocked) begin
							if (addr != 16'(push_addr)) begin
								if (r.status == STAT_OK) begin
									r.status = STAT_BAD_ADDR;
								end
							end else if (sess != SESS_NONE && push_total != 0 &&
								push_count >= push_total) begin
								if (r.status == STAT_OK) begin
									r.status = STAT_BUSY;
								end
							end else begin
								if (sess == SESS_COLLECT) begin
									crc_acc = crc_after_word(crc_acc, data);
									push_count = push_count + 24'd1;
									if (push_total != 0 && push_count == push_total) begin
										sess = (crc_acc == crc_target) ? SESS_OK : SESS_ERR;
									end
								end
								r.push_valid = 1'b1;
								r.out_data = data;
							end
						end
					end else if (r.status == STAT_OK) begin
						r.status = STAT_BAD_OP;
					end
					r.addr_echo = addr;
					r.crc_status = sess;
					expected_rsp.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_addr = 7'd63;
			cmd_addr = 7'd0;
			push_addr = 7'd1;
			words_addr = 7'd2;
			cols_addr = 7'd3;
			run_code = 8'd0;
			idle_lim = 8'd25;
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				frame_buf[i] = '0;
			end
			for (int i = 0; i < WINDOW_WORDS; i++) begin
				window[i] = '0;
			end
			fill = 0;
			idle_ticks = '0;
			crc_acc = CRC_INIT;
			crc_target = '0;
			armed = 1'b0;
			push_count = '0;
			push_total = '0;
			sess = SESS_NONE;
			expected_rsp.delete();
			error_count = 0;
			checked_count = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// response beat against the oldest expectation
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$error("response beat with nothing expected: status %0d addr 0x%0h",
						rsp.status, rsp.addr_echo);
					error_count++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("addr_echo", want.addr_echo, rsp.addr_echo);
					check_field("read_data", want.read_data, rsp.read_data);
					check_field("write_valid", want.write_valid, rsp.write_valid);
					check_field("write_addr", want.write_addr, rsp.write_addr);
					check_field("out_data", want.out_data, rsp.out_data);
					check_field("push_valid", want.push_valid, rsp.push_valid);
					check_field("crc_status", want.crc_status, rsp.crc_status);
					checked_count++;
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CRC_WORD:   crc_addr = cfg_wdata[6:0];
					CFG_CMD_WORD:   cmd_addr = cfg_wdata[6:0];
					CFG_PUSH_WORD:  push_addr = cfg_wdata[6:0];
					CFG_IMG_WORDS:  words_addr = cfg_wdata[6:0];
					CFG_IMG_COLS:   cols_addr = cfg_wdata[6:0];
					CFG_PACKED_RUN: run_code = cfg_wdata;
					CFG_IDLE_LIMIT: idle_lim = cfg_wdata;
					default: begin
					end
				endcase
			end

			// request beat
			if (req.valid && req.ready) begin
				absorb_beat(req.func, req.rx_byte);
			end

			errors <= error_count;
			pending <= expected_rsp.size();
			checked <= checked_count;
		end
	end

endmodule

>>> tb/tb_spi_frame_crc_session_engine.sv
// testbench top for spi_frame_crc_session_engine: clock, reset, request and register stimulus
// depends on sfcs_pkg, sfcs_if, the engine rtl and sfcs_response_checker
`timescale 1ns / 1ps

module tb_spi_frame_crc_session_engine;
	import sfcs_pkg::*;

	localparam int WINDOW_WORDS = 96;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [7:0] OP_RESERVED = 8'd2;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_idx;
	logic [7:0] cfg_wdata;
	int         errors, pending, checked;

	// idle and stall odds, percent per cycle
	int idle_pct;
	int stall_pct;

	// register values currently loaded
	logic [6:0] cur_crc, cur_cmd, cur_push, cur_words, cur_cols;
	logic [7:0] cur_code, cur_limit;

	int byte_beats;
	int frames;
	int sessions;

	sfcs_in_if  req_ch ();
	sfcs_out_if rsp_ch ();

	spi_frame_crc_session_engine #(.WINDOW_WORDS(WINDOW_WORDS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	sfcs_response_checker #(.WINDOW_WORDS(WINDOW_WORDS)) resp_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// response side back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// crc of the planned push words, so sessions can be armed with a matching value
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [31:0] w);
		logic [15:0] r;
		r = acc;
		for (int i = 31; i >= 0; i--) begin
			r = (r[15] ^ w[i]) ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	// one request beat, with random idle cycles ahead of it
	task automatic put_beat(input logic [1:0] f, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.func <= 2'($urandom);
			req_ch.rx_byte <= 8'($urandom);
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.rx_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		if (f == FUNC_BYTE || f == FUNC_RESYNC) begin
			byte_beats++;
		end
	endtask

	task automatic send_frame(input logic [7:0] op, input logic [15:0] addr, input logic [31:0] data);
		put_beat(FUNC_BYTE, op);
		put_beat(FUNC_BYTE, addr[15:8]);
		put_beat(FUNC_BYTE, addr[7:0]);
		put_beat(FUNC_BYTE, data[31:24]);
		put_beat(FUNC_BYTE, data[23:16]);
		put_beat(FUNC_BYTE, data[15:8]);
		put_beat(FUNC_BYTE, data[7:0]);
		frames++;
	endtask

	// drain all responses, then give the pipeline time to empty
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [6:0] crc_a, input logic [6:0] cmd_a,
		input logic [6:0] push_a, input logic [6:0] words_a, input logic [6:0] cols_a,
		input logic [7:0] code, input logic [7:0] limit);
		settle();
		put_reg(CFG_CRC_WORD, 8'(crc_a));
		put_reg(CFG_CMD_WORD, 8'(cmd_a));
		put_reg(CFG_PUSH_WORD, 8'(push_a));
		put_reg(CFG_IMG_WORDS, 8'(words_a));
		put_reg(CFG_IMG_COLS, 8'(cols_a));
		put_reg(CFG_PACKED_RUN, code);
		put_reg(CFG_IDLE_LIMIT, limit);
		cfg_we <= 1'b0;
		cur_crc = crc_a;
		cur_cmd = cmd_a;
		cur_push = push_a;
		cur_words = words_a;
		cur_cols = cols_a;
		cur_code = code;
		cur_limit = limit;
	endtask

	// well-formed session: clear, size, arm, start, push, then poke at the result
	task automatic run_session();
		int          n, c, total;
		logic [7:0]  code;
		logic [15:0] sum, target;
		logic [31:0] payload[$];
		n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
		c = $urandom_range(0, 3);
		code = $urandom_range(0, 1) ? cur_code : 8'($urandom);
		total = (code == cur_code && c != 0) ? n * c : n;
		// zero word count: session never ends, just push a few words
		if (n == 0) begin
			total = $urandom_range(1, 3);
		end
		sum = CRC_INIT;
		for (int i = 0; i < total; i++) begin
			payload.push_back($urandom);
			sum = crc16_step(sum, payload[i]);
		end
		target = ($urandom_range(0, 3) == 0) ? (sum ^ 16'($urandom_range(1, 65535))) : sum;

		send_frame(OP_WRITE, 16'(cur_cmd), $urandom);
		send_frame(OP_WRITE, 16'(cur_words), {16'($urandom), 16'(n)});
		send_frame(OP_WRITE, 16'(cur_cols), {24'($urandom), 8'(c)});
		send_frame(OP_WRITE, 16'(cur_crc), {16'($urandom), target});
		send_frame(OP_WRITE, 16'(cur_cmd), {24'($urandom), code});
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_frame(OP_READ, $urandom_range(0, 1) ? 16'(cur_crc) :
					16'($urandom_range(0, WINDOW_WORDS - 1)), $urandom);
			end
			send_frame(OP_PUSH, 16'(cur_push), payload[i]);
		end
		// overrun pushes and a write that a sticky error would drop
		repeat ($urandom_range(0, 2)) send_frame(OP_PUSH, 16'(cur_push), $urandom);
		if ($urandom_range(0, 1)) begin
			send_frame(OP_WRITE, 16'($urandom_range(0, WINDOW_WORDS - 1)), $urandom);
		end
		send_frame(OP_READ, 16'(cur_crc), $urandom);
		sessions++;
	endtask

	// random frames, broken frames, idle runs and stray beats
	task automatic noise_burst();
		int         k, run;
		logic [7:0] op;
		logic [15:0] addr;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 5))
					0: op = OP_READ;
					1: op = OP_WRITE;
					2: op = OP_PUSH;
					3: op = OP_RESERVED;
					4: op = 8'($urandom);
					default: op = OP_READ;
				endcase
				case ($urandom_range(0, 9))
					0: addr = 16'($urandom);
					1: addr = 16'(cur_crc);
					2: addr = 16'(cur_push);
					3: addr = 16'($urandom_range(WINDOW_WORDS, 127));
					default: addr = 16'($urandom_range(0, WINDOW_WORDS - 1));
				endcase
				send_frame(op, addr, $urandom);
			end
			1: begin
				repeat ($urandom_range(1, 6)) put_beat(FUNC_BYTE, 8'($urandom));
				put_beat(FUNC_RESYNC, 8'($urandom));
			end
			2: begin
				// idle run past the limit realigns, unless the count saturates first
				repeat ($urandom_range(1, 6)) put_beat(FUNC_BYTE, 8'($urandom));
				run = int'(cur_limit) + $urandom_range(1, 3);
				repeat (run) put_beat(FUNC_IDLE, 8'($urandom));
				send_frame(OP_READ, 16'($urandom_range(0, WINDOW_WORDS - 1)), $urandom);
				put_beat(FUNC_RESYNC, 8'($urandom));
			end
			3: begin
				// short idle run inside a frame keeps it going
				k = $urandom_range(1, 6);
				run = $urandom_range(1, (cur_limit < 3) ? int'(cur_limit) : 3);
				repeat (k) put_beat(FUNC_BYTE, 8'($urandom));
				repeat (run) put_beat(FUNC_IDLE, 8'($urandom));
				repeat (FRAME_BYTES - k) put_beat(FUNC_BYTE, 8'($urandom));
			end
			4: put_beat(FUNC_UNUSED, 8'($urandom));
			default: begin
				repeat ($urandom_range(1, 5)) put_beat(2'($urandom), 8'($urandom));
				put_beat(FUNC_RESYNC, 8'($urandom));
			end
		endcase
	endtask

	// edge cases on the reset register values
	task automatic directed_checks();
		logic [15:0] good;
		good = crc16_step(crc16_step(CRC_INIT, 32'hFFFF_FFFF), 32'h0000_0000);
		send_frame(OP_READ, 16'h0000, 32'h0);
		send_frame(OP_RESERVED, 16'h0005, 32'h0);
		send_frame(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_frame(OP_READ, 16'(WINDOW_WORDS), 32'h0);
		send_frame(OP_WRITE, 16'h1234, 32'hA5A5_5A5A);
		send_frame(OP_PUSH, 16'd5, 32'h0BAD_0BAD);
		send_frame(OP_PUSH, 16'(cur_push), 32'h1234_5678);
		// two-word session, zero columns so the packed code still multiplies by one
		send_frame(OP_WRITE, 16'(cur_words), 32'h0000_0002);
		send_frame(OP_WRITE, 16'(cur_cols), 32'h0);
		send_frame(OP_WRITE, 16'(cur_crc), {16'h0, good});
		send_frame(OP_WRITE, 16'(cur_cmd), {24'h0, cur_code});
		send_frame(OP_PUSH, 16'(cur_push), 32'hFFFF_FFFF);
		send_frame(OP_READ, 16'(cur_crc), 32'h0);
		send_frame(OP_PUSH, 16'(cur_push), 32'h0);
		send_frame(OP_PUSH, 16'(cur_push), 32'h1);
		// same words against a wrong crc: sticky error
		send_frame(OP_WRITE, 16'(cur_crc), {16'h0, ~good});
		send_frame(OP_WRITE, 16'(cur_cmd), {24'h0, cur_code});
		send_frame(OP_PUSH, 16'(cur_push), 32'hFFFF_FFFF);
		send_frame(OP_PUSH, 16'(cur_push), 32'h0);
		send_frame(OP_WRITE, 16'd9, 32'hDEAD_BEEF);
		send_frame(OP_READ, 16'd9, 32'h0);
		send_frame(OP_PUSH, 16'(cur_push), 32'h5555_AAAA);
		send_frame(OP_READ, 16'hFFFF, 32'h0);
		send_frame(OP_WRITE, 16'(cur_cmd), 32'h0);
		// zero word count: collects forever
		send_frame(OP_WRITE, 16'(cur_words), 32'hFFFF_0000);
		send_frame(OP_WRITE, 16'(cur_crc), 32'h0000_1D0F);
		send_frame(OP_WRITE, 16'(cur_cmd), 32'h0000_0077);
		send_frame(OP_PUSH, 16'(cur_push), 32'hFFFF_FFFF);
		// idle realign, resync and an ignored function code mid-frame
		repeat (3) put_beat(FUNC_BYTE, 8'hFF);
		repeat (int'(cur_limit) + 1) put_beat(FUNC_IDLE, 8'h00);
		send_frame(OP_READ, 16'(cur_crc), 32'h0);
		repeat (2) put_beat(FUNC_BYTE, 8'h80);
		put_beat(FUNC_RESYNC, 8'h7F);
		send_frame(OP_READ, 16'd9, 32'h0);
		repeat (3) put_beat(FUNC_BYTE, 8'h00);
		put_beat(FUNC_UNUSED, 8'hFF);
		repeat (4) put_beat(FUNC_BYTE, 8'h01);
	endtask

	task automatic random_phase(input int idle_p, input int stall_p);
		int stop_at;
		idle_pct = idle_p;
		stall_pct = stall_p;
		stop_at = byte_beats + 100;
		while (byte_beats < stop_at) begin
			if ($urandom_range(0, 99) < 45) begin
				run_session();
			end else begin
				noise_burst();
			end
		end
	endtask

	initial begin
		int base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_BYTE;
		req_ch.rx_byte = '0;
		rsp_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		byte_beats = 0;
		frames = 0;
		sessions = 0;
		cur_crc = 7'd63;
		cur_cmd = 7'd0;
		cur_push = 7'd1;
		cur_words = 7'd2;
		cur_cols = 7'd3;
		cur_code = 8'd0;
		cur_limit = 8'd25;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, no idling
		directed_checks();
		random_phase(0, 0);

		// upper extremes, sender idling
		apply_settings(7'd95, 7'd94, 7'd93, 7'd92, 7'd91, 8'hFF, 8'd255);
		random_phase(49, 0);

		// lower extremes, receiver stalling
		apply_settings(7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 8'h00, 8'd1);
		random_phase(0, 49);

		// random distinct addresses, both sides idling
		base = $urandom_range(0, WINDOW_WORDS - 5);
		apply_settings(7'(base + 4), 7'(base), 7'(base + 2), 7'(base + 1), 7'(base + 3),
			8'($urandom), 8'($urandom_range(1, 255)));
		random_phase(32, 32);

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		$display("summary: %0d responses checked from %0d frames, %0d crc sessions,",
			checked, frames, sessions);
		$display("summary: four register settings under four idle and stall mixes");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
